[hw/rtl/msas_pkg.sv]
`default_nettype none

package msas_pkg;

   // Default store depth in moves
   localparam int MAX_MOVES_DEF = 64;

   // Field widths
   localparam int SQ_W       = 6;
   localparam int KIND_W     = 4;
   localparam int PIECE_W    = 3;
   localparam int SCORE_W    = 15;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MVV_LVA_EN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROMO_EN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEST_FROM  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BEST_TO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BEST_TYPE  = 3'd4;

   // Move type codes
   localparam logic [KIND_W-1:0] KIND_CAPTURE        = 4'd4;
   localparam logic [KIND_W-1:0] KIND_PROMO_BASE     = 4'd8;
   localparam logic [KIND_W-1:0] KIND_PROMO_CAP_BASE = 4'd12;

   // Piece codes
   localparam logic [PIECE_W-1:0] PIECE_PAWN   = 3'd0;
   localparam logic [PIECE_W-1:0] PIECE_KNIGHT = 3'd1;
   localparam logic [PIECE_W-1:0] PIECE_BISHOP = 3'd2;
   localparam logic [PIECE_W-1:0] PIECE_ROOK   = 3'd3;
   localparam logic [PIECE_W-1:0] PIECE_QUEEN  = 3'd4;
   localparam logic [PIECE_W-1:0] PIECE_KING   = 3'd5;

   localparam logic signed [SCORE_W-1:0] BEST_BONUS = 15'sd10000;

   // One stored move
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [KIND_W-1:0]         kind;
      logic [SQ_W-1:0]           to_sq;
      logic [SQ_W-1:0]           from_sq;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEK,
      ST_COMPARE,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic shift_rd;
      logic shift_wr;
      logic ins_wr;
      logic emit_rd;
      logic emit_load;
      logic emit_next;
      logic batch_clear;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;
      logic pos_zero;
      logic older_lower;
      logic last;
      logic emit_done;
      logic rsp_taken;
   } status_type;

   // Material value of a piece; codes beyond king count as no piece
   function automatic logic signed [SCORE_W-1:0] piece_worth(input logic [PIECE_W-1:0] piece);
      logic signed [SCORE_W-1:0] worth;
      case (piece)
         PIECE_PAWN:   worth = 15'sd100;
         PIECE_KNIGHT: worth = 15'sd300;
         PIECE_BISHOP: worth = 15'sd300;
         PIECE_ROOK:   worth = 15'sd500;
         PIECE_QUEEN:  worth = 15'sd900;
         PIECE_KING:   worth = 15'sd1000;
         default:      worth = 15'sd0;
      endcase
      return worth;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/msas_datapath.sv]
`default_nettype none

module msas_datapath #(
   parameter int MAX_MOVES = msas_pkg::MAX_MOVES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration writes
   input  wire logic                               csr_valid,
   input  wire logic [msas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [msas_pkg::CSR_DATA_W-1:0]    csr_data,
   // incoming move
   input  wire logic [msas_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                               req_tlast,
   // outgoing move
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [msas_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output      logic                               rsp_tuser,
   output      logic                               rsp_tlast,
   // controller link
   input  wire msas_pkg::cmd_type                  cmd,
   output      msas_pkg::status_type               status
);
   import msas_pkg::*;

   localparam int IDX_W = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
   localparam int CNT_W = $clog2(MAX_MOVES + 1);

   // configuration registers
   logic              mvv_en_ff, mvv_en_in;
   logic              promo_en_ff, promo_en_in;
   logic [SQ_W-1:0]   best_from_ff, best_from_in;
   logic [SQ_W-1:0]   best_to_ff, best_to_in;
   logic [KIND_W-1:0] best_type_ff, best_type_in;

   // batch state
   entry_type         new_ff, new_in;
   logic              last_ff, last_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;

   // output register
   entry_type         out_ff, out_in;
   logic              out_drop_ff, out_drop_in;
   logic              out_final_ff, out_final_in;
   logic              out_valid_ff, out_valid_in;

   // move store
   entry_type         store_mem [MAX_MOVES];
   entry_type         rd_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   // incoming fields and score
   logic [SQ_W-1:0]           in_from;
   logic [SQ_W-1:0]           in_to;
   logic [KIND_W-1:0]         in_kind;
   logic [PIECE_W-1:0]        in_mover;
   logic [PIECE_W-1:0]        in_victim;
   logic                      is_best;
   logic                      is_capture;
   logic                      is_promo;
   logic [PIECE_W-1:0]        promo_piece;
   logic signed [SCORE_W-1:0] best_term;
   logic signed [SCORE_W-1:0] capture_term;
   logic signed [SCORE_W-1:0] promo_term;
   logic signed [SCORE_W-1:0] score;
   logic                      full;
   logic                      emit_done;

   assign in_from   = req_tdata[5:0];
   assign in_to     = req_tdata[11:6];
   assign in_kind   = req_tdata[15:12];
   assign in_mover  = req_tdata[18:16];
   assign in_victim = req_tdata[21:19];

   // score the arriving move with the registers in force
   always_comb begin
      is_best     = (in_from == best_from_ff) && (in_to == best_to_ff) &&
                    (in_kind == best_type_ff);
      is_capture  = (in_kind == KIND_CAPTURE) || (in_kind >= KIND_PROMO_CAP_BASE);
      is_promo    = (in_kind >= KIND_PROMO_BASE);
      promo_piece = PIECE_KNIGHT + {1'b0, in_kind[1:0]};
      best_term    = is_best ? BEST_BONUS : '0;
      capture_term = (mvv_en_ff && is_capture) ?
                     (piece_worth(in_victim) - piece_worth(in_mover)) : '0;
      promo_term   = (promo_en_ff && is_promo) ? piece_worth(promo_piece) : '0;
      score        = best_term + capture_term + promo_term;
   end

   assign full      = (count_ff == CNT_W'(MAX_MOVES));
   assign emit_done = ({1'b0, idx_ff} == (count_ff - CNT_W'(1)));

   // configuration writes
   always_comb begin
      mvv_en_in    = mvv_en_ff;
      promo_en_in  = promo_en_ff;
      best_from_in = best_from_ff;
      best_to_in   = best_to_ff;
      best_type_in = best_type_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MVV_LVA_EN: mvv_en_in    = csr_data[0];
            CSR_PROMO_EN:   promo_en_in  = csr_data[0];
            CSR_BEST_FROM:  best_from_in = csr_data[SQ_W-1:0];
            CSR_BEST_TO:    best_to_in   = csr_data[SQ_W-1:0];
            CSR_BEST_TYPE:  best_type_in = csr_data[KIND_W-1:0];
            default: ;
         endcase
      end
   end

   // batch bookkeeping
   always_comb begin
      new_in      = new_ff;
      last_in     = last_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.capture) begin
         new_in.from_sq = in_from;
         new_in.to_sq   = in_to;
         new_in.kind    = in_kind;
         new_in.score   = score;
         last_in        = req_tlast;
         pos_in         = count_ff[IDX_W-1:0];
         if (full) begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.shift_wr) begin
         pos_in = pos_ff - IDX_W'(1);
      end
      if (cmd.ins_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.emit_next) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.batch_clear) begin
         idx_in      = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   // store port selection
   always_comb begin
      rd_en   = cmd.shift_rd || cmd.emit_rd;
      rd_addr = cmd.emit_rd ? idx_ff : (pos_ff - IDX_W'(1));
      wr_en   = cmd.shift_wr || cmd.ins_wr;
      wr_addr = pos_ff;
      wr_data = cmd.shift_wr ? rd_ff : new_ff;
   end

   // output register
   always_comb begin
      out_in       = out_ff;
      out_drop_in  = out_drop_ff;
      out_final_in = out_final_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit_load) begin
         out_in       = rd_ff;
         out_drop_in  = overflow_ff;
         out_final_in = emit_done;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvv_en_ff    <= 1'b1;
         promo_en_ff  <= 1'b1;
         best_from_ff <= '0;
         best_to_ff   <= '0;
         best_type_ff <= '0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mvv_en_ff    <= mvv_en_in;
         promo_en_ff  <= promo_en_in;
         best_from_ff <= best_from_in;
         best_to_ff   <= best_to_in;
         best_type_ff <= best_type_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      new_ff       <= new_in;
      last_ff      <= last_in;
      out_ff       <= out_in;
      out_drop_ff  <= out_drop_in;
      out_final_ff <= out_final_in;
   end

   // move store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      status.full        = full;
      status.pos_zero    = (pos_ff == '0);
      status.older_lower = (rd_ff.score < new_ff.score);
      status.last        = last_ff;
      status.emit_done   = emit_done;
      status.rsp_taken   = out_valid_ff && rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.score, out_ff.kind, out_ff.to_sq, out_ff.from_sq};
   assign rsp_tuser  = out_drop_ff;
   assign rsp_tlast  = out_final_ff;

endmodule

`default_nettype wire

[hw/rtl/msas_ctrl.sv]
`default_nettype none

module msas_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire msas_pkg::status_type  status,
   output      msas_pkg::cmd_type     cmd
);
   import msas_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (status.full || status.pos_zero) begin
               state_in = status.last ? ST_EMIT_RD : ST_IDLE;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.older_lower) begin
               state_in = ST_SEEK;
            end else begin
               state_in = status.last ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD:   state_in = ST_EMIT_LOAD;
         ST_EMIT_LOAD: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: begin
            if (status.rsp_taken) begin
               state_in = status.emit_done ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_SEEK: begin
            if (!status.full) begin
               if (status.pos_zero) begin
                  cmd.ins_wr = 1'b1;
               end else begin
                  cmd.shift_rd = 1'b1;
               end
            end
         end
         ST_COMPARE: begin
            if (status.older_lower) begin
               cmd.shift_wr = 1'b1;
            end else begin
               cmd.ins_wr = 1'b1;
            end
         end
         ST_EMIT_RD:   cmd.emit_rd = 1'b1;
         ST_EMIT_LOAD: cmd.emit_load = 1'b1;
         ST_EMIT_WAIT: begin
            if (status.rsp_taken) begin
               if (status.emit_done) begin
                  cmd.batch_clear = 1'b1;
               end else begin
                  cmd.emit_next = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/move_score_and_sort.sv]
// An accepted move is captured and walks toward the front of the store: each step reads the
// next older stored move and, while it scores lower, writes it one place back. The move is
// stored at the front or behind one of equal or higher score. One move at a time: the next
// is taken once the last is placed or, with the store full, dropped. After the closing move,
// each sorted result is read, loaded into the output register and held until taken. Reset is
// synchronous, active high: batch cleared, registers to defaults, store contents undefined.
`default_nettype none

module move_score_and_sort #(
   parameter int MAX_MOVES = msas_pkg::MAX_MOVES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration write channel
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [msas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [msas_pkg::CSR_DATA_W-1:0]    csr_data,
   // move input
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // from_square[5:0], to_square[11:6], move_kind[15:12], mover_piece[18:16],
   // captured_piece[21:19], zero fill[23:22]
   input  wire logic [msas_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                               req_tlast,
   // sorted output
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // sorted_from[5:0], sorted_to[11:6], sorted_kind[15:12], move_score[30:16],
   // zero fill[31]
   output      logic [msas_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // dropped_flag[0]
   output      logic                               rsp_tuser,
   output      logic                               rsp_tlast
);
   import msas_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   msas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   msas_datapath #(
      .MAX_MOVES (MAX_MOVES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

[hw/rtl/msas_checker.sv]
`default_nettype none

module msas_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [msas_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                               rsp_tlast
);

   // never take a move while a result is on offer
   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // each result is fetched fresh: no back-to-back offers
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("result offered right after a transaction");

   // mid-batch the block keeps emitting and takes no move
   a_batch_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("input ready before the batch was fully emitted");

   // nothing is offered straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind move_score_and_sort msas_checker u_msas_checker (.*);

`default_nettype wire

[tb/move_order_checker.sv]
`default_nettype none

module move_order_checker #(
   parameter int CAPACITY = msas_pkg::MAX_MOVES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic [msas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [msas_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   // from_square[5:0], to_square[11:6], move_kind[15:12], mover_piece[18:16],
   // captured_piece[21:19], zero fill[23:22]
   input  wire logic [msas_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                               req_tlast,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // sorted_from[5:0], sorted_to[11:6], sorted_kind[15:12], move_score[30:16],
   // zero fill[31]
   input  wire logic [msas_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // dropped_flag[0]
   input  wire logic                               rsp_tuser,
   input  wire logic                               rsp_tlast,
   output int                                      mismatches,
   output int                                      expected_left
);
   timeunit 1ns;
   timeprecision 1ps;

   import msas_pkg::*;

   // One move held in the current batch, kept in falling score order
   typedef struct packed {
      logic [SQ_W-1:0]           from_sq;
      logic [SQ_W-1:0]           to_sq;
      logic [KIND_W-1:0]         kind;
      logic signed [SCORE_W-1:0] score;
   } held_move_type;

   // One sorted move as it should leave the block
   typedef struct packed {
      logic [SQ_W-1:0]           from_sq;
      logic [SQ_W-1:0]           to_sq;
      logic [KIND_W-1:0]         kind;
      logic signed [SCORE_W-1:0] score;
      logic                      dropped;
      logic                      closing;
   } ordered_move_type;

   held_move_type    batch_moves[$];
   ordered_move_type sorted_due[$];
   logic             batch_overflow;
   int               fault_count;

   // Scoring settings as last written
   logic              capture_on;
   logic              promo_on;
   logic [SQ_W-1:0]   best_from_sq;
   logic [SQ_W-1:0]   best_to_sq;
   logic [KIND_W-1:0] best_kind;

   initial begin
      fault_count    = 0;
      expected_left  = 0;
      batch_overflow = 1'b0;
      capture_on     = 1'b1;
      promo_on       = 1'b1;
      best_from_sq   = '0;
      best_to_sq     = '0;
      best_kind      = '0;
   end

   assign mismatches = fault_count;

   function automatic int material(input logic [PIECE_W-1:0] piece);
      case (piece)
         PIECE_PAWN:   return 100;
         PIECE_KNIGHT: return 300;
         PIECE_BISHOP: return 300;
         PIECE_ROOK:   return 500;
         PIECE_QUEEN:  return 900;
         PIECE_KING:   return 1000;
         default:      return 0;
      endcase
   endfunction

   // Ordering score: best-move bonus, capture balance, promotion gain
   function automatic logic signed [SCORE_W-1:0] order_score(
      input logic [SQ_W-1:0]    from_sq,
      input logic [SQ_W-1:0]    to_sq,
      input logic [KIND_W-1:0]  kind,
      input logic [PIECE_W-1:0] mover,
      input logic [PIECE_W-1:0] victim
   );
      int                 total;
      logic [PIECE_W-1:0] promoted;
      total    = 0;
      promoted = PIECE_KNIGHT + PIECE_W'(kind[1:0]);
      if (from_sq == best_from_sq && to_sq == best_to_sq && kind == best_kind) begin
         total += int'(BEST_BONUS);
      end
      if (capture_on && (kind == KIND_CAPTURE || kind >= KIND_PROMO_CAP_BASE)) begin
         total += material(victim) - material(mover);
      end
      if (promo_on && kind >= KIND_PROMO_BASE) begin
         total += material(promoted);
      end
      return SCORE_W'(total);
   endfunction

   always @(posedge clock) begin : track
      held_move_type    mv;
      ordered_move_type got;
      ordered_move_type want;
      int               pos;
      if (reset) begin
         capture_on     = 1'b1;
         promo_on       = 1'b1;
         best_from_sq   = '0;
         best_to_sq     = '0;
         best_kind      = '0;
         batch_overflow = 1'b0;
         batch_moves.delete();
         sorted_due.delete();
      end else begin
         // Track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MVV_LVA_EN: capture_on   = csr_data[0];
               CSR_PROMO_EN:   promo_on     = csr_data[0];
               CSR_BEST_FROM:  best_from_sq = csr_data[SQ_W-1:0];
               CSR_BEST_TO:    best_to_sq   = csr_data[SQ_W-1:0];
               CSR_BEST_TYPE:  best_kind    = csr_data[KIND_W-1:0];
               default: ;
            endcase
         end

         // Compare each sorted result against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got.from_sq = rsp_tdata[5:0];
            got.to_sq   = rsp_tdata[11:6];
            got.kind    = rsp_tdata[15:12];
            got.score   = rsp_tdata[30:16];
            got.dropped = rsp_tuser;
            got.closing = rsp_tlast;
            if (sorted_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("%0t: unexpected result from=%0d to=%0d kind=%0d score=%0d",
                           $realtime, got.from_sq, got.to_sq, got.kind, got.score);
               end
            end else begin
               want = sorted_due.pop_front();
               if (got.from_sq !== want.from_sq || got.to_sq !== want.to_sq ||
                   got.kind !== want.kind || got.score !== want.score ||
                   got.dropped !== want.dropped || got.closing !== want.closing) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display(
                        "%0t: expected from=%0d to=%0d kind=%0d score=%0d drop=%0b last=%0b",
                        $realtime, want.from_sq, want.to_sq, want.kind, want.score,
                        want.dropped, want.closing);
                     $display(
                        "%0t: actual   from=%0d to=%0d kind=%0d score=%0d drop=%0b last=%0b",
                        $realtime, got.from_sq, got.to_sq, got.kind, got.score,
                        got.dropped, got.closing);
                  end
               end
            end
         end

         // Score and insert each accepted move; equal scores stay behind older ones
         if (req_tvalid && req_tready) begin
            if (batch_moves.size() < CAPACITY) begin
               mv.from_sq = req_tdata[5:0];
               mv.to_sq   = req_tdata[11:6];
               mv.kind    = req_tdata[15:12];
               mv.score   = order_score(req_tdata[5:0], req_tdata[11:6], req_tdata[15:12],
                                        req_tdata[18:16], req_tdata[21:19]);
               batch_moves.push_back(mv);
               pos = batch_moves.size() - 1;
               while (pos > 0 && batch_moves[pos-1].score < mv.score) begin
                  batch_moves[pos] = batch_moves[pos-1];
                  pos--;
               end
               batch_moves[pos] = mv;
            end else begin
               batch_overflow = 1'b1;
            end

            // Closing move: queue the whole batch best first, then clear it
            if (req_tlast) begin
               for (int i = 0; i < batch_moves.size(); i++) begin
                  want.from_sq = batch_moves[i].from_sq;
                  want.to_sq   = batch_moves[i].to_sq;
                  want.kind    = batch_moves[i].kind;
                  want.score   = batch_moves[i].score;
                  want.dropped = batch_overflow;
                  want.closing = (i == batch_moves.size() - 1);
                  sorted_due.push_back(want);
               end
               batch_moves.delete();
               batch_overflow = 1'b0;
            end
         end
      end
      expected_left <= sorted_due.size();
   end

endmodule

`default_nettype wire

[tb/tb_move_score_and_sort.sv]
`default_nettype none

module tb_move_score_and_sort;
   timeunit 1ns;
   timeprecision 1ps;

   import msas_pkg::*;

   // Piece codes beyond king count as no piece
   localparam logic [PIECE_W-1:0] NO_PIECE_LO = 3'd6;
   localparam logic [PIECE_W-1:0] NO_PIECE_HI = 3'd7;

   localparam int SQ_MAX        = 63;
   localparam int HOLD_CYCLES   = 300;
   localparam int OVERFLOW_SIZE = MAX_MOVES_DEF + 3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tready = 1'b0;
   wire logic             csr_ready;
   wire logic             req_tready;
   wire logic             rsp_tvalid;
   wire logic [RSP_DATA_W-1:0] rsp_tdata;
   wire logic             rsp_tuser;
   wire logic             rsp_tlast;
   int                    mismatches;
   int                    expected_left;

   // Stimulus controls
   logic                  quiet         = 1'b0;
   logic                  sender_gappy  = 1'b0;
   logic                  squeeze_armed = 1'b0;
   logic                  squeeze_spent = 1'b0;
   logic [SQ_W-1:0]       cur_best_from = '0;
   logic [SQ_W-1:0]       cur_best_to   = '0;
   logic [KIND_W-1:0]     cur_best_kind = '0;

   move_score_and_sort dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   move_order_checker u_order_check (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   always #5 clock = ~clock;

   // Write one register; the caller lowers csr_valid after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic cap_on, input logic promo_on,
                            input logic [SQ_W-1:0] bf, input logic [SQ_W-1:0] bt,
                            input logic [KIND_W-1:0] bk);
      write_reg(CSR_MVV_LVA_EN, CSR_DATA_W'(cap_on));
      write_reg(CSR_PROMO_EN,   CSR_DATA_W'(promo_on));
      write_reg(CSR_BEST_FROM,  CSR_DATA_W'(bf));
      write_reg(CSR_BEST_TO,    CSR_DATA_W'(bt));
      write_reg(CSR_BEST_TYPE,  CSR_DATA_W'(bk));
      csr_valid     <= 1'b0;
      cur_best_from  = bf;
      cur_best_to    = bt;
      cur_best_kind  = bk;
   endtask

   // Offer one move and hold it until accepted; maybe idle afterwards
   task automatic send_move(input logic [SQ_W-1:0] from_sq, input logic [SQ_W-1:0] to_sq,
                            input logic [KIND_W-1:0] kind, input logic [PIECE_W-1:0] mover,
                            input logic [PIECE_W-1:0] victim, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, victim, mover, kind, to_sq, from_sq};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (sender_gappy && !quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_move(input logic last);
      logic [SQ_W-1:0]    from_sq;
      logic [SQ_W-1:0]    to_sq;
      logic [KIND_W-1:0]  kind;
      logic [PIECE_W-1:0] mover;
      logic [PIECE_W-1:0] victim;
      from_sq = SQ_W'($urandom_range(0, SQ_MAX));
      to_sq   = SQ_W'($urandom_range(0, SQ_MAX));
      kind    = KIND_W'($urandom_range(0, 15));
      mover   = ($urandom_range(0, 9) == 0) ? NO_PIECE_LO + PIECE_W'($urandom_range(0, 1))
                                            : PIECE_W'($urandom_range(0, 5));
      victim  = ($urandom_range(0, 9) == 0) ? NO_PIECE_LO + PIECE_W'($urandom_range(0, 1))
                                            : PIECE_W'($urandom_range(0, 5));
      // Hit the remembered best move now and then
      if ($urandom_range(0, 7) == 0) begin
         from_sq = cur_best_from;
         to_sq   = cur_best_to;
         kind    = cur_best_kind;
      end
      send_move(from_sq, to_sq, kind, mover, victim, last);
   endtask

   // Random batches, mostly short, until the move budget is spent
   task automatic run_batches(input int budget);
      int sent;
      int size;
      sent = 0;
      while (sent < budget) begin
         size = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
         sender_gappy = ($urandom_range(0, 2) != 0);
         for (int i = 0; i < size; i++) send_random_move(i == size - 1);
         sent += size;
      end
   endtask

   // Stop offering, wait for every sorted result, then let the block settle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Receiver: random stall bursts in stretches, plus one long hold-off
   initial begin : receiver
      int   burst;
      int   stretch;
      logic lazy;
      stretch = 0;
      lazy    = 1'b0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            lazy    = ($urandom_range(0, 1) == 1);
            stretch = $urandom_range(20, 100);
         end
         stretch--;
         if (squeeze_armed && !squeeze_spent && rsp_tvalid) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            squeeze_spent = 1'b1;
         end else if (lazy && !quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_tready <= 1'b0;
            repeat (burst) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed batch: every move kind, extreme scores, no-piece codes, ties
      configure(1'b1, 1'b1, SQ_W'(SQ_MAX), '0, KIND_PROMO_CAP_BASE + 4'd3);
      for (int k = 0; k < 16; k++) begin
         send_move(SQ_W'(k * 4), SQ_W'(SQ_MAX - k * 4), KIND_W'(k),
                   PIECE_W'(k % 6), PIECE_W'(5 - k % 6), 1'b0);
      end
      send_move(SQ_W'(SQ_MAX), '0, KIND_PROMO_CAP_BASE + 4'd3, PIECE_PAWN, PIECE_KING, 1'b0);
      send_move('0, SQ_W'(SQ_MAX), KIND_CAPTURE, PIECE_KING, NO_PIECE_HI, 1'b0);
      send_move(6'd10, 6'd20, KIND_CAPTURE, NO_PIECE_LO, PIECE_QUEEN, 1'b0);
      send_move(SQ_W'(SQ_MAX), '0, KIND_PROMO_BASE, PIECE_PAWN, PIECE_PAWN, 1'b0);
      send_move(6'd33, 6'd44, KIND_PROMO_BASE + 4'd1, PIECE_PAWN, PIECE_PAWN, 1'b1);
      // Single-move batch on the best move
      send_move(SQ_W'(SQ_MAX), '0, KIND_PROMO_CAP_BASE + 4'd3, PIECE_ROOK, PIECE_BISHOP, 1'b1);
      settle();

      // Overflow batch with the closing move dropped; hold off the output meanwhile
      configure(1'b0, 1'b0, SQ_W'($urandom_range(0, SQ_MAX)),
                SQ_W'($urandom_range(0, SQ_MAX)), KIND_W'($urandom_range(0, 15)));
      squeeze_armed = 1'b1;
      sender_gappy  = 1'b0;
      for (int i = 0; i < OVERFLOW_SIZE; i++) send_random_move(i == OVERFLOW_SIZE - 1);
      run_batches(12);
      settle();

      configure(1'b1, 1'b0, '0, SQ_W'(SQ_MAX), '0);
      run_batches(12);
      settle();

      configure(1'b0, 1'b1, SQ_W'($urandom_range(0, SQ_MAX)),
                SQ_W'($urandom_range(0, SQ_MAX)), KIND_W'($urandom_range(0, 15)));
      run_batches(12);
      settle();

      // Closing stretch at full rate
      quiet = 1'b1;
      configure(1'b1, 1'b1, SQ_W'($urandom_range(0, SQ_MAX)),
                SQ_W'($urandom_range(0, SQ_MAX)), KIND_W'($urandom_range(0, 15)));
      run_batches(12);
      settle();

      if (mismatches == 0 && expected_left == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
